// ----- hdl/ebfe_pkg.sv -----
// Shared types, constants and floating point helpers of the float eraser.
package ebfe_pkg;

  localparam logic [63:0] MaxDiffReset = 64'h3F50624DD2F1A9FC;
  localparam logic [10:0] EraseOffsetReset = 11'd1065;
  localparam logic [10:0] ExpAllOnes = 11'h7ff;
  localparam logic [63:0] CanonNan = 64'h7FF8000000000000;

  localparam logic CfgMaxDiff = 1'b0;
  localparam logic CfgEraseOffset = 1'b1;

  typedef struct packed {
    logic [63:0]       value;
    logic [2:0][63:0]  masked;
    logic [2:0]        qual;
    logic              special;
  } ebfe_item_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SUB,
    B_CNT,
    B_DONE
  } back_state_e;

  function automatic logic is_nan(input logic [63:0] x);
    return (x[62:52] == ExpAllOnes) && (x[51:0] != 52'd0);
  endfunction

  function automatic logic is_special(input logic [63:0] x);
    return x[62:52] == ExpAllOnes;
  endfunction

  // a <= b in IEEE order, false if either is NaN
  function automatic logic fle(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ka;
    logic [63:0] kb;
    ka = a[63] ? ~a : {1'b1, a[62:0]};
    kb = b[63] ? ~b : {1'b1, b[62:0]};
    if (is_nan(a) || is_nan(b)) begin
      return 1'b0;
    end
    if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
      return 1'b1;
    end
    return ka <= kb;
  endfunction

  function automatic logic [6:0] count_tz(input logic [63:0] x);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 63; i >= 0; i--) begin
      if (x[i]) n = 7'(i);
    end
    return n;
  endfunction

  function automatic logic [6:0] count_lz(input logic [63:0] x);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

endpackage

// ----- hdl/error_bounded_float_eraser_unit.sv -----
// Error-bounded float eraser: each double sample in gives one erased double out.
// A front pipeline computes the candidates v+max_diff, v and v-max_diff, masks their
// low mantissa bits and checks each against the error bound; it takes one word per
// cycle while in_stall_o is low. A queue of QueueDepth words feeds the back end,
// which subtracts the sample from the stored last result in a four stage adder,
// counts zeros and picks the winner; that loop through the stored value means the
// back end finishes each word before it takes the next. Configuration is written
// by index: 0 is max_diff_bits, 1 is erase_offset (low 11 data bits).
module error_bounded_float_eraser_unit
  import ebfe_pkg::*;
#(
  parameter int QueueDepth = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] erased_bits_o,
  output logic        reused_previous_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  localparam int OccW = $clog2(QueueDepth + 1);
  localparam logic [OccW-1:0] OccFull = OccW'(QueueDepth);

  logic [63:0] max_diff_q;
  logic [10:0] erase_offset_q;
  logic [OccW-1:0] occ_q;
  logic        accept, push, pop, q_valid;
  ebfe_item_t  push_item, head;

  assign in_stall_o = occ_q == OccFull;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_diff_q     <= MaxDiffReset;
      erase_offset_q <= EraseOffsetReset;
      occ_q          <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CfgMaxDiff) max_diff_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CfgEraseOffset) erase_offset_q <= cfg_data_i[10:0];
      occ_q <= occ_q + {{(OccW-1){1'b0}}, accept} - {{(OccW-1){1'b0}}, pop};
    end
  end

  ebfe_front u_front (
    .clk_i, .rst_ni, .valid_i(accept), .value_i(value_bits_i),
    .max_diff_i(max_diff_q), .erase_offset_i(erase_offset_q),
    .push_o(push), .item_o(push_item)
  );

  ebfe_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .item_i(push_item), .pop_i(pop),
    .not_empty_o(q_valid), .head_o(head)
  );

  ebfe_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_head_i(head), .pop_o(pop),
    .max_diff_i(max_diff_q), .out_valid_o, .out_stall_i, .erased_bits_o,
    .reused_previous_o
  );

endmodule

// ----- hdl/ebfe_fadd.sv -----
// Four stage double precision adder, round to nearest even.
module ebfe_fadd
  import ebfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        valid_o,
  output logic [63:0] sum_o
);

  logic [3:0] vld_q;

  // stage 1: unpack, swap, align
  logic        s1_sign_q, s1_sub_q, s1_nan_q, s1_inf_q, s1_infs_q;
  logic [10:0] s1_e_q;
  logic [55:0] s1_ma_q, s1_mb_q;

  logic        swap, a_inf, b_inf;
  logic [63:0] big, sml;
  logic [10:0] e_big, e_sml, e_diff;
  logic [5:0]  shamt;
  logic [55:0] mb_ext, mb_al;
  logic        sticky;

  always_comb begin
    swap   = b_i[62:0] > a_i[62:0];
    big    = swap ? b_i : a_i;
    sml    = swap ? a_i : b_i;
    e_big  = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    e_sml  = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
    e_diff = e_big - e_sml;
    shamt  = (e_diff > 11'd63) ? 6'd63 : e_diff[5:0];
    mb_ext = {(sml[62:52] != 11'd0), sml[51:0], 3'b000};
    sticky = |(mb_ext & ~({56{1'b1}} << shamt));
    mb_al  = (mb_ext >> shamt) | {55'd0, sticky};
    a_inf  = is_special(a_i) && !is_nan(a_i);
    b_inf  = is_special(b_i) && !is_nan(b_i);
  end

  always_ff @(posedge clk_i) begin
    s1_sign_q <= big[63];
    s1_sub_q  <= a_i[63] ^ b_i[63];
    s1_nan_q  <= is_nan(a_i) || is_nan(b_i) || (a_inf && b_inf && (a_i[63] != b_i[63]));
    s1_inf_q  <= a_inf || b_inf;
    s1_infs_q <= a_inf ? a_i[63] : b_i[63];
    s1_e_q    <= e_big;
    s1_ma_q   <= {(big[62:52] != 11'd0), big[51:0], 3'b000};
    s1_mb_q   <= mb_al;
  end

  // stage 2: add or subtract magnitudes
  logic        s2_sign_q, s2_zs_q, s2_nan_q, s2_inf_q, s2_infs_q;
  logic [10:0] s2_e_q;
  logic [56:0] s2_sum_q;

  always_ff @(posedge clk_i) begin
    s2_sign_q <= s1_sign_q;
    s2_zs_q   <= s1_sub_q ? 1'b0 : s1_sign_q;
    s2_nan_q  <= s1_nan_q;
    s2_inf_q  <= s1_inf_q;
    s2_infs_q <= s1_infs_q;
    s2_e_q    <= s1_e_q;
    s2_sum_q  <= s1_sub_q ? ({1'b0, s1_ma_q} - {1'b0, s1_mb_q})
                          : ({1'b0, s1_ma_q} + {1'b0, s1_mb_q});
  end

  // stage 3: leading zero count
  logic        s3_sign_q, s3_zs_q, s3_nan_q, s3_inf_q, s3_infs_q;
  logic [10:0] s3_e_q;
  logic [56:0] s3_sum_q;
  logic [5:0]  s3_lz_q;
  logic [5:0]  lz;

  always_comb begin
    lz = 6'd56;
    for (int i = 0; i < 56; i++) begin
      if (s2_sum_q[i]) lz = 6'(55 - i);
    end
  end

  always_ff @(posedge clk_i) begin
    s3_sign_q <= s2_sign_q;
    s3_zs_q   <= s2_zs_q;
    s3_nan_q  <= s2_nan_q;
    s3_inf_q  <= s2_inf_q;
    s3_infs_q <= s2_infs_q;
    s3_e_q    <= s2_e_q;
    s3_sum_q  <= s2_sum_q;
    s3_lz_q   <= lz;
  end

  // stage 4: normalize, round, pack
  logic [55:0] n;
  logic [11:0] e2, lim, shl, efin;
  logic        up;
  logic [53:0] m;
  logic [51:0] frac;
  logic [63:0] res_d;
  logic [63:0] sum_q;

  always_comb begin
    lim = {1'b0, s3_e_q} - 12'd1;
    shl = ({6'd0, s3_lz_q} < lim) ? {6'd0, s3_lz_q} : lim;
    if (s3_sum_q[56]) begin
      n  = {s3_sum_q[56:2], s3_sum_q[1] | s3_sum_q[0]};
      e2 = {1'b0, s3_e_q} + 12'd1;
    end else begin
      n  = s3_sum_q[55:0] << shl[5:0];
      e2 = {1'b0, s3_e_q} - shl;
    end
    up = n[2] && (n[1] || n[0] || n[3]);
    m  = {1'b0, n[55:3]} + {53'd0, up};
    if (m[53]) begin
      efin = e2 + 12'd1;
      frac = m[52:1];
    end else if (m[52]) begin
      efin = e2;
      frac = m[51:0];
    end else begin
      efin = 12'd0;
      frac = m[51:0];
    end
    if (s3_nan_q) begin
      res_d = CanonNan;
    end else if (s3_inf_q) begin
      res_d = {s3_infs_q, ExpAllOnes, 52'd0};
    end else if (s3_sum_q == 57'd0) begin
      res_d = {s3_zs_q, 63'd0};
    end else if (efin >= {1'b0, ExpAllOnes}) begin
      res_d = {s3_sign_q, ExpAllOnes, 52'd0};
    end else begin
      res_d = {s3_sign_q, efin[10:0], frac};
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 4'd0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  assign valid_o = vld_q[3];
  assign sum_o   = sum_q;

endmodule

// ----- hdl/ebfe_front.sv -----
// Front end: builds the three masked candidates and their error check.
module ebfe_front
  import ebfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [63:0] value_i,
  input  logic [63:0] max_diff_i,
  input  logic [10:0] erase_offset_i,
  output logic        push_o,
  output ebfe_item_t  item_o
);

  logic        add_hi_vld, add_lo_vld;
  logic [63:0] sum_hi, sum_lo;
  logic [63:0] v_pipe_q [4];

  ebfe_fadd u_add_hi (
    .clk_i, .rst_ni, .valid_i(valid_i), .a_i(value_i), .b_i(max_diff_i),
    .valid_o(add_hi_vld), .sum_o(sum_hi)
  );

  ebfe_fadd u_add_lo (
    .clk_i, .rst_ni, .valid_i(valid_i), .a_i(value_i),
    .b_i({~max_diff_i[63], max_diff_i[62:0]}),
    .valid_o(add_lo_vld), .sum_o(sum_lo)
  );

  always_ff @(posedge clk_i) begin
    v_pipe_q[0] <= value_i;
    for (int i = 1; i < 4; i++) v_pipe_q[i] <= v_pipe_q[i-1];
  end

  // mask stage
  logic [2:0][63:0] cand, masked_d;
  logic [2:0][63:0] masked_q;
  logic [63:0]      vm_q;
  logic             mvld_q;

  always_comb begin
    logic signed [12:0] cnt;
    cand[0] = sum_hi;
    cand[1] = v_pipe_q[3];
    cand[2] = sum_lo;
    for (int i = 0; i < 3; i++) begin
      cnt = $signed({2'b00, erase_offset_i}) - $signed({2'b00, cand[i][62:52]});
      if (cnt < 0) begin
        masked_d[i] = cand[i];
      end else if (cnt >= 13'sd64) begin
        masked_d[i] = 64'd0;
      end else begin
        masked_d[i] = cand[i] & ({64{1'b1}} << cnt[5:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    masked_q <= masked_d;
    vm_q     <= v_pipe_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvld_q <= 1'b0;
    end else begin
      mvld_q <= add_hi_vld && add_lo_vld;
    end
  end

  // error check of each masked candidate
  logic [2:0]       dvld;
  logic [2:0][63:0] diff;
  logic [2:0][63:0] mk_pipe_q [4];
  logic [63:0]      v2_pipe_q [4];

  for (genvar g = 0; g < 3; g++) begin : g_chk
    ebfe_fadd u_add_chk (
      .clk_i, .rst_ni, .valid_i(mvld_q), .a_i(masked_q[g]),
      .b_i({~vm_q[63], vm_q[62:0]}),
      .valid_o(dvld[g]), .sum_o(diff[g])
    );
  end

  always_ff @(posedge clk_i) begin
    mk_pipe_q[0] <= masked_q;
    v2_pipe_q[0] <= vm_q;
    for (int i = 1; i < 4; i++) begin
      mk_pipe_q[i] <= mk_pipe_q[i-1];
      v2_pipe_q[i] <= v2_pipe_q[i-1];
    end
  end

  ebfe_item_t item_q;
  logic       push_q;

  always_ff @(posedge clk_i) begin
    item_q.value   <= v2_pipe_q[3];
    item_q.masked  <= mk_pipe_q[3];
    item_q.special <= is_special(v2_pipe_q[3]);
    for (int i = 0; i < 3; i++) begin
      item_q.qual[i] <= fle({1'b0, diff[i][62:0]}, max_diff_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_q <= 1'b0;
    end else begin
      push_q <= &dvld;
    end
  end

  assign push_o = push_q;
  assign item_o = item_q;

endmodule

// ----- hdl/ebfe_queue.sv -----
// Small FIFO between the front end and the back end.
module ebfe_queue
  import ebfe_pkg::*;
#(
  parameter int Depth = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  ebfe_item_t item_i,
  input  logic       pop_i,
  output logic       not_empty_o,
  output ebfe_item_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  ebfe_item_t mem_q [Depth];
  ebfe_item_t head_q;
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            avail_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
    head_q <= mem_q[rd_q];
  end

  // head register is registered from mem_q[rd_q]; avail_q is cleared by a pop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
      avail_q <= 1'b0;
    end else begin
      if (push_i) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      cnt_q   <= cnt_q + {{PtrW{1'b0}}, push_i} - {{PtrW{1'b0}}, pop_i};
      avail_q <= (cnt_q != '0) && !pop_i;
    end
  end

  assign not_empty_o = avail_q;
  assign head_o      = head_q;

endmodule

// ----- hdl/ebfe_back.sv -----
// Back end: reuse test against the stored value and candidate selection.
module ebfe_back
  import ebfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  ebfe_item_t  q_head_i,
  output logic        pop_o,
  input  logic [63:0] max_diff_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] erased_bits_o,
  output logic        reused_previous_o
);

  back_state_e state_q, state_d;
  ebfe_item_t  item_q;
  logic [63:0] last_q, last_d;
  logic        reuse_q;
  logic [2:0][6:0] tz_q, lz_q;
  logic        out_valid_q, out_valid_d;
  logic [63:0] erased_q, erased_d;
  logic        reused_q, reused_d;
  logic        sub_vld;
  logic [63:0] sub_res;
  logic        fire;

  ebfe_fadd u_add_prev (
    .clk_i, .rst_ni, .valid_i(pop_o), .a_i(last_q),
    .b_i({~q_head_i.value[63], q_head_i.value[62:0]}),
    .valid_o(sub_vld), .sum_o(sub_res)
  );

  assign fire = (state_q == B_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (q_valid_i) state_d = B_SUB;
      B_SUB:  if (sub_vld) state_d = B_CNT;
      B_CNT:  state_d = B_DONE;
      B_DONE: if (fire) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    logic       found;
    logic [6:0] bt, bl;
    pop_o    = (state_q == B_IDLE) && q_valid_i;
    found    = 1'b0;
    bt       = 7'd0;
    bl       = 7'd0;
    erased_d = 64'd0;
    for (int i = 0; i < 3; i++) begin
      if (item_q.qual[i] && (!found || (tz_q[i] >= bt && lz_q[i] >= bl))) begin
        found    = 1'b1;
        bt       = tz_q[i];
        bl       = lz_q[i];
        erased_d = item_q.masked[i];
      end
    end
    if (reuse_q) begin
      erased_d = last_q;
    end else if (item_q.special) begin
      erased_d = item_q.value;
    end
    reused_d    = reuse_q;
    last_d      = fire ? erased_d : last_q;
    out_valid_d = fire || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) item_q <= q_head_i;
    if (sub_vld) reuse_q <= fle({1'b0, sub_res[62:0]}, max_diff_i);
    if (state_q == B_CNT) begin
      for (int i = 0; i < 3; i++) begin
        tz_q[i] <= count_tz(item_q.masked[i] ^ last_q);
        lz_q[i] <= count_lz(item_q.masked[i] ^ last_q);
      end
    end
    if (fire) begin
      erased_q <= erased_d;
      reused_q <= reused_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      last_q      <= 64'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign erased_bits_o     = erased_q;
  assign reused_previous_o = reused_q;

endmodule

// ----- hdl/ebfe_checker.sv -----
// Port level checks of the float eraser and their bind to the top level.
module ebfe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] erased_bits_o,
  input logic        reused_previous_o
);

  logic [63:0] last_seen_q;
  logic [7:0]  pend_q;
  logic        in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seen_q <= 64'd0;
      pend_q      <= 8'd0;
    end else begin
      if (out_acc) last_seen_q <= erased_bits_o;
      pend_q <= pend_q + {7'd0, in_acc} - {7'd0, out_acc};
    end
  end

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(erased_bits_o) && $stable(reused_previous_o))
    else $error("stalled result word changed");

  a_reuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reused_previous_o |-> erased_bits_o == last_seen_q)
    else $error("reused word differs from last delivered word");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 8'd0)
    else $error("result word without pending input word");

endmodule

bind error_bounded_float_eraser_unit ebfe_checker u_ebfe_checker (.*);

// ----- dv/tb_error_bounded_float_eraser_unit.sv -----
// Testbench for the error-bounded float eraser: scoreboard-checked random and directed words.
`timescale 1ns / 1ps

module tb_error_bounded_float_eraser_unit;
  import ebfe_pkg::*;

  typedef struct {
    logic [63:0] bits;
    logic        reused;
  } erased_word_t;

  class erasure_scoreboard;
    logic [63:0]  max_diff;
    logic [10:0]  erase_off;
    logic [63:0]  last_erased;
    erased_word_t pending[$];

    function new();
      max_diff    = MaxDiffReset;
      erase_off   = EraseOffsetReset;
      last_erased = '0;
    endfunction

    function real fabs(real x);
      return (x < 0.0) ? -x : x;
    endfunction

    function int trailing_zeros(logic [63:0] x);
      int n;
      n = 0;
      if (x == '0) return 64;
      while (!x[n]) n++;
      return n;
    endfunction

    function int leading_zeros(logic [63:0] x);
      int n;
      n = 0;
      if (x == '0) return 64;
      while (!x[63 - n]) n++;
      return n;
    endfunction

    function void note_sample(logic [63:0] vb);
      real          v;
      real          md;
      logic [63:0]  cand[3];
      logic [63:0]  masked;
      logic [63:0]  res;
      int           cnt, tz, lz, best_tz, best_lz;
      erased_word_t w;
      v  = $bitstoreal(vb);
      md = $bitstoreal(max_diff);
      if (fabs($bitstoreal(last_erased) - v) <= md) begin
        w.bits   = last_erased;
        w.reused = 1'b1;
        pending = {pending, w};
        return;
      end
      res = '0;
      if (vb[62:52] == ExpAllOnes) begin
        res = vb;
      end else begin
        cand[0] = $realtobits(v + md);
        cand[1] = vb;
        cand[2] = $realtobits(v - md);
        best_tz = -1;
        best_lz = -1;
        for (int i = 0; i < 3; i++) begin
          cnt = int'(erase_off) - int'(cand[i][62:52]);
          if (cnt < 0) cnt = 0;
          if (cnt > 64) cnt = 64;
          masked = (cnt == 64) ? 64'd0 : (cand[i] & ({64{1'b1}} << cnt));
          tz = trailing_zeros(masked ^ last_erased);
          lz = leading_zeros(masked ^ last_erased);
          if (tz >= best_tz && lz >= best_lz && fabs($bitstoreal(masked) - v) <= md) begin
            best_tz = tz;
            best_lz = lz;
            res = masked;
          end
        end
      end
      last_erased = res;
      w.bits   = res;
      w.reused = 1'b0;
      pending = {pending, w};
    endfunction

    function string check_word(logic [63:0] bits, logic reused);
      erased_word_t w;
      if (pending.size() == 0) return $sformatf("unexpected word %h", bits);
      w = pending.pop_front();
      if (bits !== w.bits || reused !== w.reused)
        return $sformatf("got %h/%0b, expected %h/%0b", bits, reused, w.bits, w.reused);
      return "";
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] value_bits_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] erased_bits_o;
  logic        reused_previous_o;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [63:0] cfg_data_i;

  erasure_scoreboard sb;
  int  mismatches;
  int  accepted;
  bit  quiet;

  error_bounded_float_eraser_unit dut (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic report(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      msg = sb.check_word(erased_bits_o, reused_previous_o);
      if (msg != "") report(msg);
    end
  end

  task automatic send_sample(logic [63:0] vb);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    value_bits_i <= vb;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_sample(vb);
    accepted++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_config(logic [63:0] md, logic [10:0] eo);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgMaxDiff;
    cfg_data_i <= md;
    @(posedge clk_i);
    cfg_idx_i  <= CfgEraseOffset;
    cfg_data_i <= {$urandom, 21'($urandom), eo};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.max_diff  = md;
    sb.erase_off = eo;
  endtask

  function automatic logic [63:0] random_sample(real scale);
    int  pick;
    real base;
    pick = $urandom_range(0, 99);
    if (pick < 10) return {$urandom, $urandom};
    if (pick < 14) return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 11'h7ff,
                           $urandom_range(0, 1) ? 52'd0 : {20'($urandom), $urandom}};
    if (pick < 18) return {1'($urandom), 11'd0, 20'($urandom), $urandom};
    if (pick < 22) return {1'($urandom), 63'd0};
    base = $bitstoreal(sb.last_erased);
    if (base != base || base > 1.0e300 || base < -1.0e300 || pick < 30)
      base = (real'($urandom_range(0, 2000000)) - 1000000.0) * scale;
    return $realtobits(base + (real'($urandom_range(0, 2000)) - 1000.0) * scale * 1.0e-3);
  endfunction

  task automatic random_phase(int n, real scale);
    for (int i = 0; i < n; i++) send_sample(random_sample(scale));
    drain();
  endtask

  initial begin
    // receiver: one long hold to back up the queue, then random stall bursts
    out_stall_i <= 1'b0;
    wait (accepted >= 60);
    @(posedge clk_i);
    out_stall_i <= 1'b1;
    for (int c = 0; c < 400; c++) @(posedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [63:0] directed[$];
    sb = new();
    mismatches = 0;
    accepted   = 0;
    quiet      = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    value_bits_i = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CfgMaxDiff;
    cfg_data_i   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{64'h0000000000000000, 64'h8000000000000000, 64'h7FF0000000000000,
                 64'hFFF0000000000000, 64'h7FF8000000000000, 64'h7FF0000000000001,
                 64'h0000000000000001, 64'h8000000000000001, 64'h7FEFFFFFFFFFFFFF,
                 64'hFFEFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 64'h3FF0000000000000,
                 $realtobits(1.0005), $realtobits(1.0015), $realtobits(1.0e-100),
                 $realtobits(1.0e300), $realtobits(-3.14159), $realtobits(-3.1412),
                 64'h000FFFFFFFFFFFFF, $realtobits(123456.789)};
    foreach (directed[i]) send_sample(directed[i]);
    drain();

    random_phase(150, 1.0);
    write_config($realtobits(0.5), 11'd1055);
    random_phase(120, 10.0);
    write_config(64'h0, 11'd0);
    random_phase(80, 1.0);
    write_config($realtobits(1.0e10), 11'd2047);
    random_phase(80, 1.0e6);
    write_config({1'b1, 63'($realtobits(0.01))}, 11'd1075);
    random_phase(40, 1.0);
    write_config(64'h7FF8000000000001, 11'd1040);
    random_phase(30, 1.0);
    write_config(64'hFFFFFFFFFFFFFFFF, 11'd1000);
    random_phase(20, 1.0);
    write_config($realtobits(1.0e-6), 11'd1040);
    random_phase(120, 0.01);
    write_config(MaxDiffReset, EraseOffsetReset);
    quiet = 1'b1;
    random_phase(110, 1.0);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
